// ===== src/qrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
    localparam logic [1:0] KIND_REAL_PAIR = 2'd0;
    localparam logic [1:0] KIND_COMPLEX   = 2'd1;
    localparam logic [1:0] KIND_REPEATED  = 2'd2;
    localparam logic [1:0] KIND_DEGEN     = 2'd3;
    localparam int OUT_WIDTH = 34;
endpackage
`default_nettype wire

// ===== src/qrs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface qrs_in_if #(parameter int CW = 16) (input wire logic clk);
    logic valid;
    logic ready;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;
    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if (input wire logic clk);
    logic valid;
    logic ready;
    logic [1:0] root_kind;
    logic signed [33:0] first_value;
    logic signed [33:0] second_value;
    modport source (output valid, root_kind, first_value, second_value, input ready);
    modport sink (input valid, root_kind, first_value, second_value, output ready);
endinterface
`default_nettype wire

// ===== src/qrs_sqrt_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One stage of the digit-by-digit square root: handles NPAIR pairs.
module qrs_sqrt_stage #(
    parameter int RW = 8,
    parameter int NPAIR = 4
) (
    input  wire logic [RW-1:0]   rem_in,
    input  wire logic [RW-1:0]   root_in,
    input  wire logic [2*NPAIR-1:0] pairs,
    output logic      [RW-1:0]   rem_out,
    output logic      [RW-1:0]   root_out
);
    always_comb
    begin
        logic [RW-1:0] r;
        logic [RW-1:0] q;
        logic [RW-1:0] t;
        r = rem_in;
        q = root_in;
        for (int i = NPAIR - 1; i >= 0; i--)
        begin
            r = {r[RW-3:0], pairs[2*i+1], pairs[2*i]};
            t = {q[RW-3:0], 2'b01};
            if (r >= t)
            begin
                r = r - t;
                q = {q[RW-2:0], 1'b1};
            end
            else
            begin
                q = {q[RW-2:0], 1'b0};
            end
        end
        rem_out  = r;
        root_out = q;
    end
endmodule
`default_nettype wire

// ===== src/qrs_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring division steps on magnitudes; NSTEP quotient bits per stage.
module qrs_div_stage #(
    parameter int NW = 64,
    parameter int DW = 34,
    parameter int NSTEP = 4
) (
    input  wire logic [NW-1:0] num_in,
    input  wire logic [DW:0]   rem_in,
    input  wire logic [DW-1:0] den,
    output logic      [NW-1:0] num_out,
    output logic      [DW:0]   rem_out
);
    always_comb
    begin
        logic [NW-1:0] n;
        logic [DW:0] r;
        n = num_in;
        r = rem_in;
        for (int i = 0; i < NSTEP; i++)
        begin
            r = {r[DW-1:0], n[NW-1]};
            n = {n[NW-2:0], 1'b0};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                n[0] = 1'b1;
            end
        end
        num_out = n;
        rem_out = r;
    end
endmodule
`default_nettype wire

// ===== src/quadratic_root_solver_top.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; every stage of the
// discriminant, the square-root chain and the two divider chains holds
// its own item. A stall freezes the whole pipeline when the output
// register is full and out_ch.ready is low.
// Reset (rst_n, asynchronous, active low) clears all valid bits.
`default_nettype none
module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = 16,
    parameter int RESULT_FRAC_BITS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    qrs_in_if.sink   in_ch,
    qrs_out_if.source out_ch
);
    import qrs_pkg::*;
    localparam int CW   = COEF_WIDTH;
    localparam int F    = RESULT_FRAC_BITS;
    localparam int DMW  = 2 * CW + 2;           // |D| magnitude width
    localparam int SQP  = (DMW + 2 * F + 1) / 2; // pairs
    localparam int SQRW = SQP + 2;
    localparam int SQ_N = 4;
    localparam int SQ_ST = (SQP + SQ_N - 1) / SQ_N;
    localparam int SQPAD = SQ_ST * SQ_N;
    localparam int NUMW = CW + F + 2;           // |-B*2^F +- S| width
    localparam int DENW = CW + 1;
    localparam int DV_N = 4;
    localparam int DV_ST = (NUMW + DV_N - 1) / DV_N;
    localparam int NUMP = DV_ST * DV_N;
    localparam int SW = SQP;                    // root width
    localparam int NST = 2 + SQ_ST + DV_ST;

    logic adv;
    logic [NST-1:0] vld_reg;
    logic out_v_reg;
    assign adv = !out_v_reg || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg   <= {vld_reg[NST-2:0], in_ch.valid};
            out_v_reg <= vld_reg[NST-1];
        end
    end

    // Stage 0: products of the coefficient magnitudes.
    logic signed [CW-1:0] a0_reg, b0_reg;
    logic [2*CW-1:0] q0_reg, p0_reg;
    logic sgn0_reg;
    logic [CW-1:0] ma0, mb0, mc0;
    assign ma0 = in_ch.coef_a[CW-1] ? CW'(-in_ch.coef_a) : in_ch.coef_a;
    assign mb0 = in_ch.coef_b[CW-1] ? CW'(-in_ch.coef_b) : in_ch.coef_b;
    assign mc0 = in_ch.coef_c[CW-1] ? CW'(-in_ch.coef_c) : in_ch.coef_c;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a0_reg <= in_ch.coef_a;
            b0_reg <= in_ch.coef_b;
            q0_reg <= (2*CW)'(mb0) * (2*CW)'(mb0);
            p0_reg <= (2*CW)'(ma0) * (2*CW)'(mc0);
            sgn0_reg <= (in_ch.coef_a[CW-1] != in_ch.coef_c[CW-1]) && (in_ch.coef_c != '0);
        end
    end

    // Stage 1: discriminant sign and magnitude.
    logic signed [CW-1:0] a1_reg, b1_reg;
    logic [DMW-1:0] d1_reg;
    logic neg1_reg;
    logic [DMW-1:0] q_ext, f_ext;
    assign q_ext = DMW'(q0_reg);
    assign f_ext = {p0_reg, 2'b00};
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= a0_reg;
            b1_reg <= b0_reg;
            if (sgn0_reg)
            begin
                d1_reg <= q_ext + f_ext;
                neg1_reg <= 1'b0;
            end
            else if (q_ext >= f_ext)
            begin
                d1_reg <= q_ext - f_ext;
                neg1_reg <= 1'b0;
            end
            else
            begin
                d1_reg <= f_ext - q_ext;
                neg1_reg <= 1'b1;
            end
        end
    end

    // Square-root chain.
    logic [2*SQPAD-1:0] sop;
    assign sop = (2*SQPAD)'({d1_reg, {(2*F){1'b0}}});
    logic [SQRW-1:0] srem_reg [1:SQ_ST];
    logic [SQRW-1:0] sroot_reg [1:SQ_ST];
    logic [2*SQPAD-1:0] sop_reg [1:SQ_ST];
    logic signed [CW-1:0] sa_reg [1:SQ_ST];
    logic signed [CW-1:0] sb_reg [1:SQ_ST];
    logic sneg_reg [1:SQ_ST];
    logic szero_reg [1:SQ_ST];
    for (genvar g = 0; g < SQ_ST; g++)
    begin : g_sq
        logic [SQRW-1:0] rin, qin, rn, qn;
        logic [2*SQPAD-1:0] oin;
        logic signed [CW-1:0] ain, bin;
        logic nin, zin;
        if (g == 0)
        begin : g_head
            assign rin = '0;
            assign qin = '0;
            assign oin = sop;
            assign ain = a1_reg;
            assign bin = b1_reg;
            assign nin = neg1_reg;
            assign zin = (d1_reg == '0);
        end
        else
        begin : g_body
            assign rin = srem_reg[g];
            assign qin = sroot_reg[g];
            assign oin = sop_reg[g];
            assign ain = sa_reg[g];
            assign bin = sb_reg[g];
            assign nin = sneg_reg[g];
            assign zin = szero_reg[g];
        end
        qrs_sqrt_stage #(.RW(SQRW), .NPAIR(SQ_N)) u_sq (
            .rem_in(rin), .root_in(qin),
            .pairs(oin[2*SQPAD-1 -: 2*SQ_N]),
            .rem_out(rn), .root_out(qn)
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                srem_reg[g+1]  <= rn;
                sroot_reg[g+1] <= qn;
                sop_reg[g+1]   <= oin << (2*SQ_N);
                sa_reg[g+1]    <= ain;
                sb_reg[g+1]    <= bin;
                sneg_reg[g+1]  <= nin;
                szero_reg[g+1] <= zin;
            end
        end
    end

    // Numerators and denominator, sign-magnitude form.
    logic signed [NUMW-1:0] nb_s, s_s, n1_s, n2_s;
    logic signed [CW-1:0] af;
    logic [1:0] kind_s;
    assign af = sa_reg[SQ_ST];
    assign nb_s = -(NUMW'(sb_reg[SQ_ST]) <<< F);
    assign s_s = NUMW'($signed({1'b0, sroot_reg[SQ_ST][SW-1:0]}));
    always_comb
    begin
        if (af == '0)
            kind_s = KIND_DEGEN;
        else if (szero_reg[SQ_ST])
            kind_s = KIND_REPEATED;
        else if (sneg_reg[SQ_ST])
            kind_s = KIND_COMPLEX;
        else
            kind_s = KIND_REAL_PAIR;
        unique case (kind_s)
            KIND_REAL_PAIR:
            begin
                n1_s = nb_s + s_s;
                n2_s = nb_s - s_s;
            end
            KIND_COMPLEX:
            begin
                n1_s = nb_s;
                n2_s = s_s;
            end
            default:
            begin
                n1_s = nb_s;
                n2_s = nb_s;
            end
        endcase
    end

    logic [NUMP-1:0] dn1_reg [1:DV_ST];
    logic [NUMP-1:0] dn2_reg [1:DV_ST];
    logic [DENW:0]   dr1_reg [1:DV_ST];
    logic [DENW:0]   dr2_reg [1:DV_ST];
    logic [DENW-1:0] dd_reg  [1:DV_ST];
    logic ds1_reg [1:DV_ST];
    logic ds2_reg [1:DV_ST];
    logic [1:0] dk_reg [1:DV_ST];
    logic adn;
    logic [CW-1:0] amag;
    logic [NUMP-1:0] div_n1, div_n2;
    logic [DENW-1:0] div_d;
    logic div_s1, div_s2;
    assign adn = af[CW-1];
    assign amag = adn ? CW'(-af) : af;
    always_comb
    begin
        div_n1 = NUMP'(n1_s[NUMW-1] ? -n1_s : n1_s);
        div_n2 = NUMP'(n2_s[NUMW-1] ? -n2_s : n2_s);
        div_d  = {amag, 1'b0};
        div_s1 = n1_s[NUMW-1] ^ adn;
        div_s2 = n2_s[NUMW-1] ^ adn;
    end
    for (genvar g = 0; g < DV_ST; g++)
    begin : g_dv
        logic [NUMP-1:0] n1i, n2i, n1n, n2n;
        logic [DENW:0] r1i, r2i, r1n, r2n;
        logic [DENW-1:0] di;
        logic s1i, s2i;
        logic [1:0] ki;
        if (g == 0)
        begin : g_head
            assign n1i = div_n1;
            assign n2i = div_n2;
            assign r1i = '0;
            assign r2i = '0;
            assign di  = div_d;
            assign s1i = div_s1;
            assign s2i = div_s2;
            assign ki  = kind_s;
        end
        else
        begin : g_body
            assign n1i = dn1_reg[g];
            assign n2i = dn2_reg[g];
            assign r1i = dr1_reg[g];
            assign r2i = dr2_reg[g];
            assign di  = dd_reg[g];
            assign s1i = ds1_reg[g];
            assign s2i = ds2_reg[g];
            assign ki  = dk_reg[g];
        end
        qrs_div_stage #(.NW(NUMP), .DW(DENW), .NSTEP(DV_N)) u_d1 (
            .num_in(n1i), .rem_in(r1i), .den(di),
            .num_out(n1n), .rem_out(r1n)
        );
        qrs_div_stage #(.NW(NUMP), .DW(DENW), .NSTEP(DV_N)) u_d2 (
            .num_in(n2i), .rem_in(r2i), .den(di),
            .num_out(n2n), .rem_out(r2n)
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dn1_reg[g+1] <= n1n;
                dn2_reg[g+1] <= n2n;
                dr1_reg[g+1] <= r1n;
                dr2_reg[g+1] <= r2n;
                dd_reg[g+1]  <= di;
                ds1_reg[g+1] <= s1i;
                ds2_reg[g+1] <= s2i;
                dk_reg[g+1]  <= ki;
            end
        end
    end

    function automatic logic [OUT_WIDTH-1:0] sat(input logic [NUMP-1:0] m, input logic s);
        logic [NUMP:0] lim;
        lim = (NUMP+1)'(1) << (OUT_WIDTH - 1);
        if (!s)
            sat = ({1'b0, m} >= lim) ? {1'b0, {(OUT_WIDTH-1){1'b1}}} : OUT_WIDTH'(m);
        else
            sat = ({1'b0, m} >= lim) ? {1'b1, {(OUT_WIDTH-1){1'b0}}} : OUT_WIDTH'(-m);
    endfunction

    logic [1:0] kind_reg;
    logic [OUT_WIDTH-1:0] v1_reg, v2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg <= dk_reg[DV_ST];
            v1_reg <= (dk_reg[DV_ST] == KIND_DEGEN) ? '0 : sat(dn1_reg[DV_ST], ds1_reg[DV_ST]);
            v2_reg <= (dk_reg[DV_ST] == KIND_DEGEN) ? '0 : sat(dn2_reg[DV_ST], ds2_reg[DV_ST]);
        end
    end
    assign out_ch.valid = out_v_reg;
    assign out_ch.root_kind = kind_reg;
    assign out_ch.first_value = $signed(v1_reg);
    assign out_ch.second_value = $signed(v2_reg);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !out_ch.ready |=> out_v_reg && $stable(kind_reg))
        else $error("result lost under stall");
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && kind_reg == KIND_DEGEN |-> v1_reg == '0 && v2_reg == '0)
        else $error("degenerate result not zero");
    a_rep: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && kind_reg == KIND_REPEATED |-> v1_reg == v2_reg)
        else $error("repeated root mismatch");
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import qrs_pkg::*;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 300;
    localparam longint VAL_MAX = 64'sd8589934591;
    localparam longint VAL_MIN = -64'sd8589934592;

    typedef struct packed {
        logic [1:0] kind;
        logic signed [33:0] first;
        logic signed [33:0] second;
    } roots_t;

    logic clk;
    logic rst_n;
    roots_t expected_roots[$];
    int errors;
    int cycles;
    bit send_busy;
    bit recv_busy;

    qrs_in_if #(.CW(16)) in_ch (clk);
    qrs_out_if out_ch (clk);

    quadratic_root_solver_top u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor(sqrt(x)); x stays below 2^68, so the root fits in 34 bits.
    function automatic longint root_floor(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int i = 40; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= x)
                r = t;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [33:0] clamp34(longint v);
        if (v > VAL_MAX)
            v = VAL_MAX;
        if (v < VAL_MIN)
            v = VAL_MIN;
        return v[33:0];
    endfunction

    function automatic roots_t solve_roots(logic signed [15:0] a, logic signed [15:0] b,
                                           logic signed [15:0] c);
        roots_t res;
        longint disc;
        longint mag;
        longint den;
        longint nb;
        longint s;
        disc = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
        den = 2 * longint'(a);
        nb = -longint'(b) * (64'sd1 <<< FRAC);
        if (a == 0)
        begin
            res.kind = KIND_DEGEN;
            res.first = '0;
            res.second = '0;
        end
        else if (disc == 0)
        begin
            res.kind = KIND_REPEATED;
            res.first = clamp34(nb / den);
            res.second = res.first;
        end
        else
        begin
            mag = (disc < 0) ? -disc : disc;
            s = root_floor({64'd0, mag} << (2 * FRAC));
            if (disc < 0)
            begin
                res.kind = KIND_COMPLEX;
                res.first = clamp34(nb / den);
                res.second = clamp34(s / den);
            end
            else
            begin
                res.kind = KIND_REAL_PAIR;
                res.first = clamp34((nb + s) / den);
                res.second = clamp34((nb - s) / den);
            end
        end
        return res;
    endfunction

    task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                              logic signed [15:0] c);
        int gap;
        gap = send_busy ? 0 : $urandom_range(0, 15);
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.coef_a <= a;
        in_ch.coef_b <= b;
        in_ch.coef_c <= c;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_roots.push_back(solve_roots(a, b, c));
    endtask

    task automatic send_random(int n);
        logic signed [15:0] k;
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
            begin
                send_busy = ($urandom_range(0, 3) == 0);
                recv_busy = ($urandom_range(0, 3) == 0);
            end
            case ($urandom_range(0, 7))
                0: send_coefs(16'sd0, 16'($urandom), 16'($urandom));
                1:
                begin
                    // Perfect square: b = 2k, a = c = k gives a zero discriminant.
                    k = 16'($urandom_range(0, 16383));
                    if ($urandom_range(0, 1))
                        k = -k;
                    if (k == 0)
                        k = 1;
                    send_coefs(k, 16'(2 * k), k);
                end
                2: send_coefs(16'(int'($urandom_range(0, 1023)) - 512),
                              16'(int'($urandom_range(0, 1023)) - 512),
                              16'(int'($urandom_range(0, 1023)) - 512));
                default: send_coefs(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
        end
        send_busy = 1'b0;
        recv_busy = 1'b0;
    endtask

    task automatic test_degenerate();
        send_coefs(16'sd0, 16'sd0, 16'sd0);
        send_coefs(16'sd0, -16'sd32768, 16'sd32767);
        send_coefs(16'sd0, 16'sd32767, -16'sd32768);
    endtask

    task automatic test_real_pair();
        send_coefs(16'sd256, 16'sd0, -16'sd256);
        send_coefs(-16'sd256, 16'sd768, 16'sd1024);
        send_coefs(16'sd1, -16'sd32768, -16'sd32768);
    endtask

    task automatic test_complex();
        send_coefs(16'sd256, 16'sd0, 16'sd256);
        send_coefs(-16'sd256, 16'sd256, -16'sd1024);
        send_coefs(16'sd32767, 16'sd1, 16'sd32767);
    endtask

    task automatic test_repeated();
        send_coefs(16'sd256, 16'sd512, 16'sd256);
        send_coefs(-16'sd1, 16'sd0, 16'sd0);
        send_coefs(-16'sd16384, 16'sd32767 - 16'sd32767 - 16'sd32768, -16'sd16384);
    endtask

    task automatic test_extremes();
        logic signed [15:0] lim[4];
        lim = '{-16'sd32768, 16'sd32767, 16'sd1, -16'sd1};
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j += 3)
                send_coefs(lim[i], lim[j], lim[(i + j + 1) % 4]);
    endtask

    // Result side: random stall per item (none while recv_busy), outputs compared at the accepting edge.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = recv_busy ? 0 : $urandom_range(0, 15);
            repeat (stall)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        roots_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_roots.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
            end
            else
            begin
                exp_r = expected_roots.pop_front();
                if (out_ch.root_kind !== exp_r.kind)
                begin
                    $error("root_kind expected %0d got %0d", exp_r.kind, out_ch.root_kind);
                    errors++;
                end
                if (out_ch.first_value !== exp_r.first)
                begin
                    $error("first_value expected %0d got %0d", exp_r.first,
                           out_ch.first_value);
                    errors++;
                end
                if (out_ch.second_value !== exp_r.second)
                begin
                    $error("second_value expected %0d got %0d", exp_r.second,
                           out_ch.second_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quadratic_root_solver_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        send_busy = 1'b0;
        recv_busy = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.coef_a = '0;
        in_ch.coef_b = '0;
        in_ch.coef_c = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_degenerate();
        test_real_pair();
        test_complex();
        test_repeated();
        test_extremes();
        send_random(430);

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("quadratic_root_solver_top: match");
        else
            $display("quadratic_root_solver_top: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
